[hdl/prpz_pkg.sv]
package prpz_pkg;

  // Store geometry
  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HEIGHT      = 128;
  localparam int DEPTH_FRAC_BITS = 24;
  localparam int STORE_SIZE      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W          = $clog2(STORE_SIZE);
  localparam int LIM_W           = ADDR_W + 1;
  localparam int DEPTH_W         = DEPTH_FRAC_BITS + 1;
  localparam int WE_W            = $clog2(MAX_WIDTH + 1);
  localparam int HE_W            = $clog2(MAX_HEIGHT + 1);

  // Scene constants
  localparam int CAM_DIST    = 110;
  localparam int SCREEN_DIST = 40;
  localparam int SYM_SCALE   = 1000;
  localparam int SYM_OFFSET  = 66;
  localparam int RED_GAIN    = 10;
  localparam int RED_OFFSET  = 50;
  localparam int RED_MAX     = 255;
  // smallest shade that clamps red
  localparam int RED_SAT     = (RED_MAX - RED_OFFSET) / RED_GAIN + 1;

  // Field widths
  localparam int COORD_W = 8;
  localparam int ANGLE_W = 16;
  localparam int SW_W    = 9;
  localparam int SH_W    = 8;
  localparam int PIX_W   = 15;
  localparam int SYM_W   = 8;
  localparam int RED_W   = 8;
  localparam int CFG_IDX_W = 3;

  // Rotation datapath widths (Q14, Q28, Q28)
  localparam int ROT1_W = 25;
  localparam int ROT2_W = 40;
  localparam int ROT3_W = 41;

  // Shared MAC
  localparam int MAC_A_W = 51;
  localparam int MAC_B_W = 17;
  localparam int ACC_W   = MAC_A_W + MAC_B_W;

  // Shared restoring divider
  localparam int DIV_W   = (DEPTH_FRAC_BITS + 29 > 50) ? DEPTH_FRAC_BITS + 29 : 50;
  localparam int DEN_W   = ROT3_W;
  localparam int CNT_W   = $clog2(DIV_W);
  localparam int SHADE_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIN_X, CFG_COS_X, CFG_SIN_Y, CFG_COS_Y,
    CFG_SIN_Z, CFG_COS_Z, CFG_WIDTH, CFG_HEIGHT
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE,
    ST_Y1A, ST_Y1B, ST_Z1A, ST_Z1B, ST_X2A, ST_X2B,
    ST_Z2A, ST_Z2B, ST_X3A, ST_X3B, ST_Y3A, ST_Y3B,
    ST_LIM, ST_XNA, ST_XNB, ST_XDIV, ST_YNA, ST_YNB, ST_YDIV, ST_ODIV,
    ST_POSA, ST_POSB, ST_RD, ST_CMP, ST_DONE
  } st_t;

endpackage

[hdl/prpz_if.sv]
interface prpz_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [prpz_pkg::COORD_W-1:0]    point_x;
  logic signed [prpz_pkg::COORD_W-1:0]    point_y;
  logic signed [prpz_pkg::COORD_W-1:0]    point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface prpz_out_if;
  logic                          valid;
  logic                          ready;
  logic                          drawn;
  logic [prpz_pkg::PIX_W-1:0]    pixel_index;
  logic [prpz_pkg::SYM_W-1:0]    symbol;
  logic [prpz_pkg::RED_W-1:0]    red;
  modport source (output valid, drawn, pixel_index, symbol, red, input ready);
  modport sink   (input valid, drawn, pixel_index, symbol, red, output ready);
endinterface

interface prpz_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [prpz_pkg::CFG_IDX_W-1:0]    index;
  logic [prpz_pkg::ANGLE_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/point_rotate_project_zbuffer.sv]
// Each point is rotated, projected and depth-tested in turn; a point behind the camera
//   skips projection and depth test. A new point is taken only once the last result is registered.
// Projection uses the shared 1-bit/cycle divider, run three times per point in front of the camera.
// Reset (rst_n low, synchronous) loads the default angles and screen size, then a
//   clearing pass zeroes the depth store, one entry a cycle over all STORE_SIZE (32768)
//   entries, before the first input transfer. Config writes are taken at all times.
module point_rotate_project_zbuffer (
  input  logic        clk,
  input  logic        rst_n,
  prpz_in_if.sink     in_bus,
  prpz_out_if.source  out_bus,
  prpz_cfg_if.sink    cfg_bus
);

  // ---------------------------------------------------------------- state
  prpz_pkg::st_t state_r, state_nxt;

  // configuration
  logic signed [prpz_pkg::ANGLE_W-1:0] sin_x_r, cos_x_r, sin_y_r, cos_y_r, sin_z_r, cos_z_r;
  logic [prpz_pkg::SW_W-1:0] width_r;
  logic [prpz_pkg::SH_W-1:0] height_r;
  logic [prpz_pkg::WE_W-1:0] w_eff;
  logic [prpz_pkg::HE_W-1:0] h_eff;

  // captured point and intermediate results
  logic signed [prpz_pkg::COORD_W-1:0] pt_x_r, pt_y_r, pt_z_r;
  logic signed [prpz_pkg::ROT1_W-1:0]  y1_r, z1_r;
  logic signed [prpz_pkg::ROT2_W-1:0]  x2_r;
  logic signed [prpz_pkg::ROT3_W-1:0]  x3_r, y3_r, z_r;
  logic [prpz_pkg::LIM_W-1:0]          lim_r;
  logic signed [prpz_pkg::MAC_A_W-1:0] xp_r, yp_r;
  logic [prpz_pkg::DEPTH_W-1:0]        ooz_r;
  logic [prpz_pkg::ADDR_W-1:0]         idx_r;
  logic                                inb_r, drawn_r, hit;
  logic [prpz_pkg::SHADE_W-1:0]        shade_r;

  // shared MAC: acc_r +/- a*b
  logic signed [prpz_pkg::MAC_A_W-1:0] mac_a;
  logic signed [prpz_pkg::MAC_B_W-1:0] mac_b;
  logic                                mac_sub;
  logic signed [prpz_pkg::ACC_W-1:0]   acc_r, prod, mac_sum, mac_abs;

  // shared divider, dividend shifts out of quo_r as quotient shifts in
  logic [prpz_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [prpz_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [prpz_pkg::DEN_W:0]   div_trial, div_den;
  logic                       div_ge, div_last, neg_r;
  logic [prpz_pkg::CNT_W-1:0] cnt_r;

  // depth store
  logic [prpz_pkg::DEPTH_W-1:0] depth_mem [prpz_pkg::STORE_SIZE];
  logic [prpz_pkg::DEPTH_W-1:0] rd_data_r, mem_wdata;
  logic [prpz_pkg::ADDR_W-1:0]  mem_waddr, clr_cnt_r;
  logic                         mem_we;

  // output register
  logic                        out_valid_r, out_drawn_r, out_load;
  logic [prpz_pkg::PIX_W-1:0]  out_idx_r;
  logic [prpz_pkg::SYM_W-1:0]  out_sym_r;
  logic [prpz_pkg::RED_W-1:0]  out_red_r;

  logic in_xfer, cfg_xfer;

  assign in_xfer  = in_bus.valid && in_bus.ready;
  assign cfg_xfer = cfg_bus.valid && cfg_bus.ready;

  // screen size clamps to the store
  assign w_eff = (32'(width_r) > 32'(prpz_pkg::MAX_WIDTH)) ?
                 prpz_pkg::WE_W'(prpz_pkg::MAX_WIDTH) : prpz_pkg::WE_W'(width_r);
  assign h_eff = (32'(height_r) > 32'(prpz_pkg::MAX_HEIGHT)) ?
                 prpz_pkg::HE_W'(prpz_pkg::MAX_HEIGHT) : prpz_pkg::HE_W'(height_r);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prpz_pkg::ST_CLR: begin
        if (clr_cnt_r == prpz_pkg::ADDR_W'(prpz_pkg::STORE_SIZE - 1)) state_nxt = prpz_pkg::ST_IDLE;
      end
      prpz_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = prpz_pkg::ST_Y1A;
      end
      prpz_pkg::ST_Y1A: state_nxt = prpz_pkg::ST_Y1B;
      prpz_pkg::ST_Y1B: state_nxt = prpz_pkg::ST_Z1A;
      prpz_pkg::ST_Z1A: state_nxt = prpz_pkg::ST_Z1B;
      prpz_pkg::ST_Z1B: state_nxt = prpz_pkg::ST_X2A;
      prpz_pkg::ST_X2A: state_nxt = prpz_pkg::ST_X2B;
      prpz_pkg::ST_X2B: state_nxt = prpz_pkg::ST_Z2A;
      prpz_pkg::ST_Z2A: state_nxt = prpz_pkg::ST_Z2B;
      prpz_pkg::ST_Z2B: state_nxt = prpz_pkg::ST_X3A;
      prpz_pkg::ST_X3A: state_nxt = prpz_pkg::ST_X3B;
      prpz_pkg::ST_X3B: state_nxt = prpz_pkg::ST_Y3A;
      prpz_pkg::ST_Y3A: state_nxt = prpz_pkg::ST_Y3B;
      prpz_pkg::ST_Y3B: begin
        // behind the camera: nothing drawn
        state_nxt = (z_r > 0) ? prpz_pkg::ST_LIM : prpz_pkg::ST_DONE;
      end
      prpz_pkg::ST_LIM:  state_nxt = prpz_pkg::ST_XNA;
      prpz_pkg::ST_XNA:  state_nxt = prpz_pkg::ST_XNB;
      prpz_pkg::ST_XNB:  state_nxt = prpz_pkg::ST_XDIV;
      prpz_pkg::ST_XDIV: begin
        if (div_last) state_nxt = prpz_pkg::ST_YNA;
      end
      prpz_pkg::ST_YNA:  state_nxt = prpz_pkg::ST_YNB;
      prpz_pkg::ST_YNB:  state_nxt = prpz_pkg::ST_YDIV;
      prpz_pkg::ST_YDIV: begin
        if (div_last) state_nxt = prpz_pkg::ST_ODIV;
      end
      prpz_pkg::ST_ODIV: begin
        if (div_last) state_nxt = prpz_pkg::ST_POSA;
      end
      prpz_pkg::ST_POSA: state_nxt = prpz_pkg::ST_POSB;
      prpz_pkg::ST_POSB: state_nxt = prpz_pkg::ST_RD;
      prpz_pkg::ST_RD:   state_nxt = prpz_pkg::ST_CMP;
      prpz_pkg::ST_CMP:  state_nxt = prpz_pkg::ST_DONE;
      prpz_pkg::ST_DONE: begin
        if (out_load) state_nxt = prpz_pkg::ST_IDLE;
      end
      default: state_nxt = prpz_pkg::ST_CLR;
    endcase
  end

  // ---------------------------------------------------------------- outputs / MAC operands
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_sub = 1'b0;
    unique case (state_r)
      // y1 = j*cx - k*sx
      prpz_pkg::ST_Y1A: begin mac_a = prpz_pkg::MAC_A_W'(pt_y_r); mac_b = prpz_pkg::MAC_B_W'(cos_x_r); end
      prpz_pkg::ST_Y1B: begin
        mac_a = prpz_pkg::MAC_A_W'(pt_z_r); mac_b = prpz_pkg::MAC_B_W'(sin_x_r); mac_sub = 1'b1;
      end
      // z1 = j*sx + k*cx
      prpz_pkg::ST_Z1A: begin mac_a = prpz_pkg::MAC_A_W'(pt_y_r); mac_b = prpz_pkg::MAC_B_W'(sin_x_r); end
      prpz_pkg::ST_Z1B: begin mac_a = prpz_pkg::MAC_A_W'(pt_z_r); mac_b = prpz_pkg::MAC_B_W'(cos_x_r); end
      // x2 = x1*cy + z1*sy, x1 = i << 14
      prpz_pkg::ST_X2A: begin
        mac_a = prpz_pkg::MAC_A_W'(pt_x_r) <<< 14; mac_b = prpz_pkg::MAC_B_W'(cos_y_r);
      end
      prpz_pkg::ST_X2B: begin mac_a = prpz_pkg::MAC_A_W'(z1_r); mac_b = prpz_pkg::MAC_B_W'(sin_y_r); end
      // z2 = z1*cy - x1*sy
      prpz_pkg::ST_Z2A: begin mac_a = prpz_pkg::MAC_A_W'(z1_r); mac_b = prpz_pkg::MAC_B_W'(cos_y_r); end
      prpz_pkg::ST_Z2B: begin
        mac_a = prpz_pkg::MAC_A_W'(pt_x_r) <<< 14; mac_b = prpz_pkg::MAC_B_W'(sin_y_r);
        mac_sub = 1'b1;
      end
      // x3 = x2*cz - y2*sz, y2 = y1 << 14
      prpz_pkg::ST_X3A: begin mac_a = prpz_pkg::MAC_A_W'(x2_r); mac_b = prpz_pkg::MAC_B_W'(cos_z_r); end
      prpz_pkg::ST_X3B: begin
        mac_a = prpz_pkg::MAC_A_W'(y1_r) <<< 14; mac_b = prpz_pkg::MAC_B_W'(sin_z_r);
        mac_sub = 1'b1;
      end
      // y3 = x2*sz + y2*cz
      prpz_pkg::ST_Y3A: begin mac_a = prpz_pkg::MAC_A_W'(x2_r); mac_b = prpz_pkg::MAC_B_W'(sin_z_r); end
      prpz_pkg::ST_Y3B: begin
        mac_a = prpz_pkg::MAC_A_W'(y1_r) <<< 14; mac_b = prpz_pkg::MAC_B_W'(cos_z_r);
      end
      prpz_pkg::ST_LIM: begin mac_a = prpz_pkg::MAC_A_W'(h_eff); mac_b = prpz_pkg::MAC_B_W'(w_eff); end
      // numerators of the projection
      prpz_pkg::ST_XNA: begin
        mac_a = prpz_pkg::MAC_A_W'(z_r); mac_b = prpz_pkg::MAC_B_W'(w_eff >> 1);
      end
      prpz_pkg::ST_XNB: begin
        mac_a = prpz_pkg::MAC_A_W'(x3_r); mac_b = prpz_pkg::MAC_B_W'(2 * prpz_pkg::SCREEN_DIST);
      end
      prpz_pkg::ST_YNA: begin
        mac_a = prpz_pkg::MAC_A_W'(z_r); mac_b = prpz_pkg::MAC_B_W'(h_eff >> 1);
      end
      prpz_pkg::ST_YNB: begin
        mac_a = prpz_pkg::MAC_A_W'(y3_r); mac_b = prpz_pkg::MAC_B_W'(prpz_pkg::SCREEN_DIST);
      end
      // pos = yp*w + xp
      prpz_pkg::ST_POSA: begin mac_a = yp_r; mac_b = prpz_pkg::MAC_B_W'(w_eff); end
      prpz_pkg::ST_POSB: begin mac_a = xp_r; mac_b = prpz_pkg::MAC_B_W'(1); end
      prpz_pkg::ST_CMP: begin
        mac_a = prpz_pkg::MAC_A_W'(ooz_r); mac_b = prpz_pkg::MAC_B_W'(prpz_pkg::SYM_SCALE);
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  always_comb begin
    in_bus.ready  = (state_r == prpz_pkg::ST_IDLE);
    cfg_bus.ready = 1'b1;
    out_load      = (state_r == prpz_pkg::ST_DONE) && (!out_valid_r || out_bus.ready);
    hit           = inb_r && (ooz_r > rd_data_r);
    mem_we        = (state_r == prpz_pkg::ST_CLR) || ((state_r == prpz_pkg::ST_CMP) && hit);
    mem_waddr     = (state_r == prpz_pkg::ST_CLR) ? clr_cnt_r : idx_r;
    mem_wdata     = (state_r == prpz_pkg::ST_CLR) ? '0 : ooz_r;
    div_last      = (cnt_r == prpz_pkg::CNT_W'(prpz_pkg::DIV_W - 1));
  end

  assign prod    = mac_a * mac_b;
  assign mac_sum = mac_sub ? acc_r - prod : acc_r + prod;
  assign mac_abs = mac_sum[prpz_pkg::ACC_W-1] ? -mac_sum : mac_sum;

  // one restoring step per cycle; divisor is z (positive here)
  assign div_den   = {1'b0, $unsigned(z_r)};
  assign div_trial = {rem_r, quo_r[prpz_pkg::DIV_W-1]};
  assign div_ge    = (div_trial >= div_den);
  assign rem_nxt   = div_ge ? prpz_pkg::DEN_W'(div_trial - div_den) : prpz_pkg::DEN_W'(div_trial);
  assign quo_nxt   = {quo_r[prpz_pkg::DIV_W-2:0], div_ge};

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prpz_pkg::ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      sin_x_r     <= '0;
      cos_x_r     <= prpz_pkg::ANGLE_W'(16384);
      sin_y_r     <= '0;
      cos_y_r     <= prpz_pkg::ANGLE_W'(16384);
      sin_z_r     <= '0;
      cos_z_r     <= prpz_pkg::ANGLE_W'(16384);
      width_r     <= prpz_pkg::SW_W'(80);
      height_r    <= prpz_pkg::SH_W'(40);
    end else begin
      state_r <= state_nxt;
      if (state_r == prpz_pkg::ST_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_xfer) begin
        unique case (prpz_pkg::cfg_idx_t'(cfg_bus.index))
          prpz_pkg::CFG_SIN_X:  sin_x_r  <= cfg_bus.data;
          prpz_pkg::CFG_COS_X:  cos_x_r  <= cfg_bus.data;
          prpz_pkg::CFG_SIN_Y:  sin_y_r  <= cfg_bus.data;
          prpz_pkg::CFG_COS_Y:  cos_y_r  <= cfg_bus.data;
          prpz_pkg::CFG_SIN_Z:  sin_z_r  <= cfg_bus.data;
          prpz_pkg::CFG_COS_Z:  cos_z_r  <= cfg_bus.data;
          prpz_pkg::CFG_WIDTH:  width_r  <= prpz_pkg::SW_W'(cfg_bus.data);
          prpz_pkg::CFG_HEIGHT: height_r <= prpz_pkg::SH_W'(cfg_bus.data);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    acc_r <= mac_sum;   // the A half of every MAC pair starts from zero below
    if (state_r == prpz_pkg::ST_XDIV || state_r == prpz_pkg::ST_YDIV ||
        state_r == prpz_pkg::ST_ODIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    unique case (state_r)
      prpz_pkg::ST_IDLE: begin
        pt_x_r  <= in_bus.point_x;
        pt_y_r  <= in_bus.point_y;
        pt_z_r  <= in_bus.point_z;
        drawn_r <= 1'b0;
        acc_r   <= '0;
      end
      prpz_pkg::ST_Y1B: begin y1_r <= prpz_pkg::ROT1_W'(mac_sum); acc_r <= '0; end
      prpz_pkg::ST_Z1B: begin z1_r <= prpz_pkg::ROT1_W'(mac_sum); acc_r <= '0; end
      prpz_pkg::ST_X2B: begin x2_r <= prpz_pkg::ROT2_W'(mac_sum); acc_r <= '0; end
      prpz_pkg::ST_Z2B: begin
        z_r   <= prpz_pkg::ROT3_W'(mac_sum + (prpz_pkg::ACC_W'(prpz_pkg::CAM_DIST) <<< 28));
        acc_r <= '0;
      end
      // Q42 -> Q28, floored
      prpz_pkg::ST_X3B: begin x3_r <= prpz_pkg::ROT3_W'(mac_sum >>> 14); acc_r <= '0; end
      prpz_pkg::ST_Y3B: begin y3_r <= prpz_pkg::ROT3_W'(mac_sum >>> 14); acc_r <= '0; end
      prpz_pkg::ST_LIM: begin lim_r <= prpz_pkg::LIM_W'(mac_sum); acc_r <= '0; end
      prpz_pkg::ST_XNB, prpz_pkg::ST_YNB: begin
        neg_r <= mac_sum[prpz_pkg::ACC_W-1];
        quo_r <= prpz_pkg::DIV_W'(mac_abs);
        rem_r <= '0;
        cnt_r <= '0;
        acc_r <= '0;
      end
      prpz_pkg::ST_XDIV: begin
        if (div_last) begin
          xp_r <= neg_r ? -prpz_pkg::MAC_A_W'(quo_nxt) : prpz_pkg::MAC_A_W'(quo_nxt);
        end
        acc_r <= '0;
      end
      prpz_pkg::ST_YDIV: begin
        if (div_last) begin
          yp_r  <= neg_r ? -prpz_pkg::MAC_A_W'(quo_nxt) : prpz_pkg::MAC_A_W'(quo_nxt);
          // 1/z dividend
          quo_r <= prpz_pkg::DIV_W'(1) << (prpz_pkg::DEPTH_FRAC_BITS + 28);
          rem_r <= '0;
          cnt_r <= '0;
        end
        acc_r <= '0;
      end
      prpz_pkg::ST_ODIV: begin
        if (div_last) begin
          ooz_r <= (quo_nxt > prpz_pkg::DIV_W'({prpz_pkg::DEPTH_W{1'b1}})) ?
                   '1 : prpz_pkg::DEPTH_W'(quo_nxt);
        end
        acc_r <= '0;
      end
      prpz_pkg::ST_POSB: begin
        inb_r <= !mac_sum[prpz_pkg::ACC_W-1] && (mac_sum < prpz_pkg::ACC_W'(lim_r));
        idx_r <= prpz_pkg::ADDR_W'(mac_sum);
        acc_r <= '0;
      end
      prpz_pkg::ST_CMP: begin
        drawn_r <= hit;
        shade_r <= prpz_pkg::SHADE_W'(mac_sum >>> prpz_pkg::DEPTH_FRAC_BITS);
      end
      default: begin
        if (state_r == prpz_pkg::ST_CLR || state_r == prpz_pkg::ST_DONE) acc_r <= '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- depth store
  always_ff @(posedge clk) begin
    if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= depth_mem[idx_r];
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drawn_r <= drawn_r;
      out_idx_r   <= drawn_r ? prpz_pkg::PIX_W'(idx_r) : '0;
      out_sym_r   <= drawn_r ? prpz_pkg::SYM_W'(shade_r) + prpz_pkg::SYM_W'(prpz_pkg::SYM_OFFSET) : '0;
      if (!drawn_r) begin
        out_red_r <= '0;
      end else if (shade_r >= prpz_pkg::SHADE_W'(prpz_pkg::RED_SAT)) begin
        out_red_r <= prpz_pkg::RED_W'(prpz_pkg::RED_MAX);
      end else begin
        out_red_r <= prpz_pkg::RED_W'(shade_r) * prpz_pkg::RED_W'(prpz_pkg::RED_GAIN)
                     + prpz_pkg::RED_W'(prpz_pkg::RED_OFFSET);
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.drawn       = out_drawn_r;
  assign out_bus.pixel_index = out_idx_r;
  assign out_bus.symbol      = out_sym_r;
  assign out_bus.red         = out_red_r;

  // ---------------------------------------------------------------- checks
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == prpz_pkg::ST_Y1A))
    else $error("transfer did not start the sequence");

  a_rose_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == prpz_pkg::ST_DONE))
    else $error("result raised outside the finish step");

  a_write_drawn: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == prpz_pkg::ST_CMP) && mem_we) |=> drawn_r)
    else $error("depth written without a drawn result");

  a_ooz_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == prpz_pkg::ST_DONE) && drawn_r) |-> (ooz_r != '0))
    else $error("drawn point with zero depth");

endmodule

[bench/prpz_tb_if.sv]
`timescale 1ns / 100ps
// Channel interfaces come with the RTL (hdl/prpz_if.sv); nothing extra needed here.
package prpz_tb_pkg;
  import prpz_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } point_t;

  typedef struct packed {
    logic             drawn;
    logic [PIX_W-1:0] pixel_index;
    logic [SYM_W-1:0] symbol;
    logic [RED_W-1:0] red;
  } pixel_t;
endpackage

[bench/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import prpz_pkg::*;
  import prpz_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  prpz_in_if  in_bus ();
  prpz_out_if out_bus ();
  prpz_cfg_if cfg_bus ();

  point_rotate_project_zbuffer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block's registers and depth store
  logic signed [ANGLE_W-1:0] sx, cx, sy, cy, sz, cz;
  logic [SW_W-1:0]           scr_w;
  logic [SH_W-1:0]           scr_h;
  logic [DEPTH_W-1:0]        zbuf [STORE_SIZE];

  pixel_t pixel_fifo[$];
  int     n_errors;
  int     n_points;
  int     n_drawn;
  int     n_pixels;
  logic   rx_stall_en;

  // floor(v / 2^14) for signed v
  function automatic longint floor14(longint v);
    return v >>> 14;
  endfunction

  // Rotate, project and depth-test one point; updates the shadow store.
  function automatic pixel_t project_point(point_t p);
    pixel_t    r;
    longint    i, j, k, x1, y1, z1, x2, y2, z2, x3, y3, z;
    longint    w, h, xp, yp, pos, ooz, omax, shade, rv;
    r = '0;
    i = p.px; j = p.py; k = p.pz;
    x1 = i * 16384;
    y1 = j * cx - k * sx;
    z1 = j * sx + k * cx;
    x2 = x1 * cy + z1 * sy;
    y2 = y1 * 16384;
    z2 = z1 * cy - x1 * sy;
    // Q42 products can exceed 64 bits? x2 < 2^37, angle <= 2^14: fits in 2^52
    x3 = floor14(x2 * cz - y2 * sz);
    y3 = floor14(x2 * sz + y2 * cz);
    z = z2 + (longint'(CAM_DIST) <<< 28);
    if (z <= 0) return r;               // behind the camera
    ooz = (longint'(1) <<< (DEPTH_FRAC_BITS + 28)) / z;
    omax = (longint'(1) <<< (DEPTH_FRAC_BITS + 1)) - 1;
    if (ooz > omax) ooz = omax;         // very near point saturates
    w = (scr_w > MAX_WIDTH) ? MAX_WIDTH : scr_w;
    h = (scr_h > MAX_HEIGHT) ? MAX_HEIGHT : scr_h;
    // SV division truncates toward zero, as required
    xp = ((w / 2) * z + 2 * SCREEN_DIST * x3) / z;
    yp = ((h / 2) * z + SCREEN_DIST * y3) / z;
    pos = xp + yp * w;
    if (pos < 0 || pos >= w * h || pos >= STORE_SIZE) return r;
    if (!(ooz > longint'(zbuf[pos]))) return r;
    zbuf[pos] = ooz[DEPTH_W-1:0];
    shade = (longint'(SYM_SCALE) * ooz) >>> DEPTH_FRAC_BITS;
    rv = shade * RED_GAIN + RED_OFFSET;
    if (rv > RED_MAX) rv = RED_MAX;
    r.drawn = 1'b1;
    r.pixel_index = pos[PIX_W-1:0];
    r.symbol = SYM_W'(shade + SYM_OFFSET);
    r.red = rv[RED_W-1:0];
    return r;
  endfunction

  // Register write, mirrored into the shadow copy.
  task automatic write_reg(cfg_idx_t idx, logic [ANGLE_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_SIN_X:  sx = val;
      CFG_COS_X:  cx = val;
      CFG_SIN_Y:  sy = val;
      CFG_COS_Y:  cy = val;
      CFG_SIN_Z:  sz = val;
      CFG_COS_Z:  cz = val;
      CFG_WIDTH:  scr_w = val[SW_W-1:0];
      CFG_HEIGHT: scr_h = val[SH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_angles(int a, int b, int c, int d, int e, int f);
    write_reg(CFG_SIN_X, a[15:0]);
    write_reg(CFG_COS_X, b[15:0]);
    write_reg(CFG_SIN_Y, c[15:0]);
    write_reg(CFG_COS_Y, d[15:0]);
    write_reg(CFG_SIN_Z, e[15:0]);
    write_reg(CFG_COS_Z, f[15:0]);
  endtask

  task automatic set_screen(int w, int h);
    write_reg(CFG_WIDTH, w[15:0]);
    write_reg(CFG_HEIGHT, h[15:0]);
  endtask

  // One point transfer; expectation is queued at the accepting edge.
  task automatic send_point(point_t p);
    in_bus.valid   = 1'b1;
    in_bus.point_x = p.px;
    in_bus.point_y = p.py;
    in_bus.point_z = p.pz;
    do @(posedge clk); while (!in_bus.ready);
    pixel_fifo.push_back(project_point(p));
    n_points++;
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic send_xyz(int x, int y, int z);
    point_t p;
    p.px = x[7:0]; p.py = y[7:0]; p.pz = z[7:0];
    send_point(p);
  endtask

  // Wait for the pipe to drain, plus slack
  task automatic drain();
    while (pixel_fifo.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Mostly small coordinates so points land on screen; some full range.
  function automatic point_t rand_point();
    point_t p;
    if ($urandom_range(0, 3) == 0) begin
      p.px = COORD_W'($urandom); p.py = COORD_W'($urandom); p.pz = COORD_W'($urandom);
    end else begin
      p.px = COORD_W'($urandom_range(0, 80) - 40);
      p.py = COORD_W'($urandom_range(0, 80) - 40);
      p.pz = COORD_W'($urandom_range(0, 80) - 40);
    end
    return p;
  endfunction

  // Burst sender with random gaps
  task automatic send_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < count) begin
          send_point(rand_point());
          sent++;
        end
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 300)) @(negedge clk);
    end
  endtask

  function automatic int rand_trig();
    case ($urandom_range(0, 4))
      0: return 16384;
      1: return -16384;
      2: return 0;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  // Directed: field extremes, near / behind camera, depth wins and losses
  task automatic test_directed();
    send_xyz(0, 0, 0);
    send_xyz(0, 0, 0);             // same depth: loses
    send_xyz(0, 0, -1);            // nearer: wins
    send_xyz(127, 127, 127);
    send_xyz(-128, -128, -128);
    send_xyz(-128, 127, -128);
    send_xyz(127, -128, 127);
    send_xyz(1, 1, 1);
    send_xyz(-40, 20, -100);
    send_xyz(-40, 20, 100);
    send_xyz(10, -10, -109);       // very near
    drain();
    set_angles(16384, 0, 0, 16384, 0, 16384);  // 90 deg about X
    send_xyz(0, 127, 0);           // z pushed away from the camera: in front
    send_xyz(0, -128, 0);
    send_xyz(0, 111, 3);
    send_xyz(5, -110, 3);          // z exactly 0 region
    send_xyz(0, -110, 0);
    drain();
  endtask

  // Screen size extremes including zero and over-size values
  task automatic test_screen_sizes();
    int ws[6] = '{1, 256, 511, 0, 2, 200};
    int hs[6] = '{1, 128, 255, 0, 3, 100};
    foreach (ws[n]) begin
      set_screen(ws[n], hs[n]);
      set_angles(0, 16384, 0, 16384, 0, 16384);
      send_xyz(0, 0, -50);
      send_xyz(-128, 127, -100);
      repeat (20) send_point(rand_point());
      drain();
    end
  endtask

  // Random angles and screens, many phases
  task automatic test_random_scenes();
    for (int ph = 0; ph < 12; ph++) begin
      set_angles(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                 rand_trig());
      set_screen($urandom_range(1, 300), $urandom_range(1, 140));
      send_random(117);
      drain();
    end
  endtask

  // Receiver: when enabled, stalls in a pattern of its own; checks each transfer
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rx_stall_en) out_bus.ready <= 1'b1;
    else out_bus.ready <= ((stall_phase % 37) < 28) && ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      n_pixels++;
      if (pixel_fifo.size() == 0) begin
        $error("unexpected result transfer");
        n_errors++;
      end else begin
        want = pixel_fifo.pop_front();
        if (out_bus.drawn) n_drawn++;
        if (out_bus.drawn !== want.drawn) begin
          $error("drawn: expected %0d, got %0d", want.drawn, out_bus.drawn);
          n_errors++;
        end
        if (out_bus.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index,
                 out_bus.pixel_index);
          n_errors++;
        end
        if (out_bus.symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, out_bus.symbol);
          n_errors++;
        end
        if (out_bus.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_bus.red);
          n_errors++;
        end
      end
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.point_x = '0; in_bus.point_y = '0; in_bus.point_z = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_SIN_X;
    cfg_bus.data = '0;
    rx_stall_en = 1'b0;
    n_errors = 0; n_points = 0; n_drawn = 0; n_pixels = 0;
    sx = 0; cx = 16384; sy = 0; cy = 16384; sz = 0; cz = 16384;
    scr_w = 80; scr_h = 40;
    foreach (zbuf[a]) zbuf[a] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed();               // full-speed receiver first
    rx_stall_en = 1'b1;
    test_screen_sizes();
    test_random_scenes();

    $display("Covered %0d points (%0d drawn, %0d results) over 19 register settings.",
             n_points, n_drawn, n_pixels);
    if (n_errors == 0)
      $display("** point_rotate_project_zbuffer: PASSED **");
    else
      $display("** point_rotate_project_zbuffer: FAILED **");
    $finish;
  end

  // Watchdog: ~1550 points plus gaps, stalls, clearing pass
  initial begin
    #20000000;
    $display("** point_rotate_project_zbuffer: FAILED **");
    $finish;
  end

endmodule
